### design/slbc_pkg.sv
// ----------------------------------------------------------------------------
// Status LED breathing controller package
// Shared types, codes and constants for the controller and its lane datapath.
// ----------------------------------------------------------------------------
package slbc_pkg;

  localparam int CountWidth  = 32;
  localparam int PeriodWidth = 12;
  localparam int HalfWidth   = PeriodWidth - 1;
  localparam int ScaleWidth  = 8;
  localparam int ProdWidth   = ScaleWidth + HalfWidth;
  localparam int ColorWidth  = 24;
  localparam int StepWidth   = $clog2(CountWidth);

  localparam logic [0:0] CMD_TICK  = 1'b0;
  localparam logic [0:0] CMD_EVENT = 1'b1;

  localparam logic [2:0] STS_USB_MOUNTED   = 3'd0;
  localparam logic [2:0] STS_BOOT_STARTED  = 3'd1;
  localparam logic [2:0] STS_USB_UNMOUNTED = 3'd2;
  localparam logic [2:0] STS_WRITE_START   = 3'd3;
  localparam logic [2:0] STS_WRITE_DONE    = 3'd4;
  localparam logic [2:0] STS_BLE_CONN      = 3'd5;
  localparam logic [2:0] STS_BLE_DISC      = 3'd6;

  localparam logic [1:0] CFG_BRIGHTNESS_MASK = 2'd0;
  localparam logic [1:0] CFG_LED_ACTIVE_HIGH = 2'd1;
  localparam logic [1:0] CFG_HAS_SECONDARY   = 2'd2;

  localparam logic [ScaleWidth-1:0]  PRIMARY_SCALE   = 8'h4F;
  localparam logic [ScaleWidth-1:0]  SECONDARY_SCALE = 8'h8F;
  localparam logic [ScaleWidth-1:0]  DUTY_TOP        = 8'hFF;
  localparam logic [PeriodWidth-1:0] SLOW_PERIOD     = 12'd3000;
  localparam logic [PeriodWidth-1:0] FAST_PERIOD     = 12'd300;
  localparam logic [PeriodWidth-1:0] WRITE_PERIOD    = 12'd100;
  localparam logic [ColorWidth-1:0]  COLOR_GREEN     = 24'h00FF00;
  localparam logic [ColorWidth-1:0]  COLOR_RED       = 24'hFF0000;
  localparam logic [ColorWidth-1:0]  COLOR_BLUE      = 24'h0000FF;
  localparam logic [ColorWidth-1:0]  COLOR_MAGENTA   = 24'hFF00FF;
  localparam logic [ColorWidth-1:0]  COLOR_ALL       = 24'hFFFFFF;

  typedef struct packed {
    logic       command;
    logic [2:0] status_code;
  } item_t;

  typedef struct packed {
    logic                   duty_valid;
    logic [ScaleWidth-1:0]  primary_duty;
    logic [ScaleWidth-1:0]  secondary_duty;
    logic                   color_valid;
    logic [ColorWidth-1:0]  color;
  } result_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic fold;
    logic mult;
    logic div_step;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FOLD,
    S_MULT,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### design/slbc_lane.sv
// ----------------------------------------------------------------------------
// Status LED breathing controller lane
// Bit-serial modulo of the tick count by the period, fold about half the
// period, scale multiply and bit-serial division by the half period.
// ----------------------------------------------------------------------------
module slbc_lane (
  input  logic                              clk,
  input  slbc_pkg::lane_ctrl_t              ctrl,
  input  logic [slbc_pkg::PeriodWidth-1:0]  period,
  input  logic [slbc_pkg::ScaleWidth-1:0]   scale,
  input  logic                              count_bit,
  output logic [slbc_pkg::ScaleWidth-1:0]   quot
);

  logic [slbc_pkg::PeriodWidth-1:0] rem;
  logic [slbc_pkg::HalfWidth-1:0]   phase;
  logic [slbc_pkg::HalfWidth-1:0]   div_rem;
  logic [slbc_pkg::ScaleWidth-1:0]  div_sr;

  logic [slbc_pkg::PeriodWidth:0]   mod_trial;
  logic                             mod_ge;
  logic [slbc_pkg::PeriodWidth:0]   mod_diff;
  logic [slbc_pkg::HalfWidth-1:0]   half;
  logic [slbc_pkg::PeriodWidth-1:0] fold_diff;
  logic [slbc_pkg::ProdWidth-1:0]   prod;
  logic [slbc_pkg::HalfWidth:0]     div_trial;
  logic                             div_ge;
  logic [slbc_pkg::HalfWidth:0]     div_diff;

  assign mod_trial = {rem, count_bit};
  assign mod_ge    = mod_trial >= {1'b0, period};
  assign mod_diff  = mod_trial - {1'b0, period};
  assign half      = period[slbc_pkg::PeriodWidth-1:1];
  assign fold_diff = period - rem;
  assign prod      = slbc_pkg::ProdWidth'(scale) * slbc_pkg::ProdWidth'(phase);
  assign div_trial = {div_rem, div_sr[slbc_pkg::ScaleWidth-1]};
  assign div_ge    = div_trial >= {1'b0, half};
  assign div_diff  = div_trial - {1'b0, half};
  assign quot      = div_sr;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
    end else if (ctrl.mod_step) begin
      rem <= mod_ge ? mod_diff[slbc_pkg::PeriodWidth-1:0]
                    : mod_trial[slbc_pkg::PeriodWidth-1:0];
    end
    if (ctrl.fold) begin
      if (rem > {1'b0, half}) begin
        phase <= fold_diff[slbc_pkg::HalfWidth-1:0];
      end else begin
        phase <= rem[slbc_pkg::HalfWidth-1:0];
      end
    end
    if (ctrl.mult) begin
      div_rem <= prod[slbc_pkg::ProdWidth-1:slbc_pkg::ScaleWidth];
      div_sr  <= prod[slbc_pkg::ScaleWidth-1:0];
    end else if (ctrl.div_step) begin
      div_rem <= div_ge ? div_diff[slbc_pkg::HalfWidth-1:0]
                        : div_trial[slbc_pkg::HalfWidth-1:0];
      div_sr  <= {div_sr[slbc_pkg::ScaleWidth-2:0], div_ge};
    end
  end

endmodule

### design/status_led_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// Status LED breathing controller
// Turns millisecond ticks into triangle-wave PWM compare values for two LEDs
// and status events into RGB colour writes.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) carries one tick or one
// status event per transfer. The result channel (result_valid, result_stall,
// result) returns exactly one result per item, in order. Configuration writes
// arrive on cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and writes are expected only while the block is idle.
// A tick passes from transfer to result through bit-serial modulo of the
// count by each period, a fold step, a multiply step, bit-serial division
// by the half period, and a step that loads the output register. Both
// LEDs are computed side by side. A status event goes straight to the
// output register load. One item is in work at a time; the next item is
// taken in the cycle after the finished result has moved to the output
// register, even while that register still waits for the receiver.
// When the receiver stalls, the output register holds its result and a
// finished item waits until the register frees up. Reset clears the count,
// sets both periods to 3000, clears the saved colour and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module status_led_breathing_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  slbc_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output slbc_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [slbc_pkg::ColorWidth-1:0]  cfg_data
);

  slbc_pkg::state_t                   state;
  slbc_pkg::state_t                   state_next;
  logic [slbc_pkg::StepWidth-1:0]     step_cnt;
  logic [slbc_pkg::CountWidth-1:0]    cnt_sr;
  logic [slbc_pkg::CountWidth-1:0]    tick_count;
  logic [slbc_pkg::PeriodWidth-1:0]   primary_period;
  logic [slbc_pkg::PeriodWidth-1:0]   secondary_period;
  logic [slbc_pkg::ColorWidth-1:0]    saved_color;
  logic                               temp_active;
  logic [slbc_pkg::ColorWidth-1:0]    brightness_mask;
  logic                               led_active_high;
  logic                               has_secondary;
  logic                               is_tick;
  slbc_pkg::result_t                  event_res;

  slbc_pkg::lane_ctrl_t               ctrl;
  logic                               accept;
  logic                               out_free;
  logic                               step_last;
  logic [slbc_pkg::ScaleWidth-1:0]    primary_quot;
  logic [slbc_pkg::ScaleWidth-1:0]    secondary_quot;
  slbc_pkg::result_t                  tick_res;

  logic [slbc_pkg::ColorWidth-1:0]    chosen;
  logic [slbc_pkg::ColorWidth-1:0]    masked;
  logic                               temp_hit;
  logic [slbc_pkg::PeriodWidth-1:0]   primary_period_next;
  logic [slbc_pkg::PeriodWidth-1:0]   secondary_period_next;
  logic [slbc_pkg::PeriodWidth-1:0]   ble_period;
  logic                               ble_hit;
  slbc_pkg::result_t                  event_res_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != slbc_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign step_last  = (step_cnt == slbc_pkg::StepWidth'(slbc_pkg::CountWidth - 1));

  slbc_lane u_primary (
    .clk       (clk),
    .ctrl      (ctrl),
    .period    (primary_period),
    .scale     (slbc_pkg::PRIMARY_SCALE),
    .count_bit (cnt_sr[slbc_pkg::CountWidth-1]),
    .quot      (primary_quot)
  );

  slbc_lane u_secondary (
    .clk       (clk),
    .ctrl      (ctrl),
    .period    (secondary_period),
    .scale     (slbc_pkg::SECONDARY_SCALE),
    .count_bit (cnt_sr[slbc_pkg::CountWidth-1]),
    .quot      (secondary_quot)
  );

  always_comb begin
    tick_res                = '0;
    tick_res.duty_valid     = 1'b1;
    tick_res.primary_duty   = led_active_high ? slbc_pkg::DUTY_TOP - primary_quot
                                              : primary_quot;
    tick_res.secondary_duty = led_active_high ? slbc_pkg::DUTY_TOP - secondary_quot
                                              : secondary_quot;
  end

  always_comb begin
    chosen                = saved_color;
    temp_hit              = 1'b0;
    ble_hit               = 1'b0;
    ble_period            = slbc_pkg::SLOW_PERIOD;
    primary_period_next   = primary_period;
    secondary_period_next = secondary_period;
    unique case (item.status_code) inside
      slbc_pkg::STS_USB_MOUNTED: begin
        chosen              = slbc_pkg::COLOR_GREEN;
        primary_period_next = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BOOT_STARTED, slbc_pkg::STS_USB_UNMOUNTED: begin
        chosen              = slbc_pkg::COLOR_RED;
        primary_period_next = slbc_pkg::FAST_PERIOD;
      end
      slbc_pkg::STS_WRITE_START: begin
        temp_hit            = 1'b1;
        primary_period_next = slbc_pkg::WRITE_PERIOD;
      end
      slbc_pkg::STS_WRITE_DONE: begin
        primary_period_next = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BLE_CONN: begin
        chosen     = slbc_pkg::COLOR_BLUE;
        ble_hit    = 1'b1;
        ble_period = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BLE_DISC: begin
        chosen     = slbc_pkg::COLOR_MAGENTA;
        ble_hit    = 1'b1;
        ble_period = slbc_pkg::FAST_PERIOD;
      end
      default: begin
      end
    endcase
    if (ble_hit) begin
      if (has_secondary) begin
        secondary_period_next = ble_period;
      end else begin
        primary_period_next = ble_period;
      end
    end
    masked         = chosen & brightness_mask;
    event_res_next = '0;
    if (temp_hit) begin
      event_res_next.color_valid = 1'b1;
      event_res_next.color       = slbc_pkg::COLOR_RED & brightness_mask;
    end else if (masked != saved_color) begin
      event_res_next.color_valid = 1'b1;
      event_res_next.color       = masked;
    end else if (temp_active) begin
      event_res_next.color_valid = 1'b1;
      event_res_next.color       = saved_color;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      slbc_pkg::S_IDLE: begin
        if (accept) begin
          if (item.command == slbc_pkg::CMD_TICK) begin
            ctrl.load  = 1'b1;
            state_next = slbc_pkg::S_MOD;
          end else begin
            state_next = slbc_pkg::S_DONE;
          end
        end
      end
      slbc_pkg::S_MOD: begin
        ctrl.mod_step = 1'b1;
        if (step_last) begin
          state_next = slbc_pkg::S_FOLD;
        end
      end
      slbc_pkg::S_FOLD: begin
        ctrl.fold  = 1'b1;
        state_next = slbc_pkg::S_MULT;
      end
      slbc_pkg::S_MULT: begin
        ctrl.mult  = 1'b1;
        state_next = slbc_pkg::S_DIV;
      end
      slbc_pkg::S_DIV: begin
        ctrl.div_step = 1'b1;
        if (step_cnt[2:0] == 3'd7) begin
          state_next = slbc_pkg::S_DONE;
        end
      end
      slbc_pkg::S_DONE: begin
        if (out_free) begin
          state_next = slbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = slbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.mult) begin
      step_cnt <= '0;
    end else if (ctrl.mod_step || ctrl.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
    if (ctrl.load) begin
      cnt_sr <= tick_count + 1'b1;
    end else if (ctrl.mod_step) begin
      cnt_sr <= {cnt_sr[slbc_pkg::CountWidth-2:0], 1'b0};
    end
    if (accept) begin
      is_tick   <= (item.command == slbc_pkg::CMD_TICK);
      event_res <= event_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      primary_period   <= slbc_pkg::SLOW_PERIOD;
      secondary_period <= slbc_pkg::SLOW_PERIOD;
      saved_color      <= '0;
      temp_active      <= 1'b0;
    end else if (accept) begin
      if (item.command == slbc_pkg::CMD_TICK) begin
        tick_count <= tick_count + 1'b1;
      end else begin
        primary_period   <= primary_period_next;
        secondary_period <= secondary_period_next;
        if (temp_hit) begin
          temp_active <= 1'b1;
        end else if (masked != saved_color) begin
          saved_color <= masked;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_mask <= slbc_pkg::COLOR_ALL;
      led_active_high <= 1'b1;
      has_secondary   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slbc_pkg::CFG_BRIGHTNESS_MASK: brightness_mask <= cfg_data;
        slbc_pkg::CFG_LED_ACTIVE_HIGH: led_active_high <= cfg_data[0];
        slbc_pkg::CFG_HAS_SECONDARY:   has_secondary   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == slbc_pkg::S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (state == slbc_pkg::S_DONE && out_free) begin
      result <= is_tick ? tick_res : event_res;
    end
  end

endmodule

### design/slbc_checker.sv
// ----------------------------------------------------------------------------
// Status LED breathing controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module slbc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input slbc_pkg::result_t result
);

  // A held result must not change while the receiver stalls.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Only one item is in work, so a transfer closes the item channel.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while one is in work");

  // Duty results never carry a colour, and an unused colour field is zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.color_valid |-> result.color == '0)
    else $error("colour field not zero without a colour write");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.duty_valid |-> !result.color_valid)
    else $error("duty and colour in one result");

endmodule

bind status_led_breathing_controller_unit slbc_checker u_slbc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### tb/sv/tb_status_led_breathing_controller_unit.sv
// ----------------------------------------------------------------------------
// Status LED breathing controller testbench
// Streams millisecond ticks and status events into the controller under
// random sender bursts and receiver stalls, across several register
// settings. Each result transfer is checked field by field against an
// in-order prediction of the duty values and colour writes.
// ----------------------------------------------------------------------------
module tb_status_led_breathing_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] STS_OTHER = 3'd7;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 241;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  slbc_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  slbc_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = slbc_pkg::CFG_BRIGHTNESS_MASK;
  logic [slbc_pkg::ColorWidth-1:0] cfg_data = '0;

  slbc_pkg::item_t queued_items[$];
  slbc_pkg::result_t owed_outputs[$];
  int failures = 0;

  logic [slbc_pkg::ColorWidth-1:0] mask_rgb = slbc_pkg::COLOR_ALL;
  logic active_high_led = 1'b1;
  logic secondary_fitted = 1'b1;
  logic [slbc_pkg::CountWidth-1:0] tick_total = '0;
  logic [slbc_pkg::PeriodWidth-1:0] primary_ms = slbc_pkg::SLOW_PERIOD;
  logic [slbc_pkg::PeriodWidth-1:0] secondary_ms = slbc_pkg::SLOW_PERIOD;
  logic [slbc_pkg::ColorWidth-1:0] saved_rgb = '0;
  logic temp_shown = 1'b0;

  status_led_breathing_controller_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] fold_duty(logic [slbc_pkg::CountWidth-1:0] count,
                                           logic [slbc_pkg::PeriodWidth-1:0] period,
                                           logic [7:0] scale);
    int unsigned phase;
    int unsigned half;
    int unsigned level;
    if (period == 0) begin
      return active_high_led ? slbc_pkg::DUTY_TOP : 8'h00;
    end
    phase = count % period;
    half = period / 2;
    if (phase > half) begin
      phase = period - phase;
    end
    level = (half == 0) ? 0 : (scale * phase) / half;
    if (active_high_led) begin
      level = slbc_pkg::DUTY_TOP - level;
    end
    return level[7:0];
  endfunction

  function automatic slbc_pkg::result_t next_led_outputs(slbc_pkg::item_t it);
    slbc_pkg::result_t r;
    logic [slbc_pkg::ColorWidth-1:0] chosen;
    logic [slbc_pkg::ColorWidth-1:0] temp;
    r = '0;
    if (it.command == slbc_pkg::CMD_TICK) begin
      tick_total = tick_total + 1;
      r.duty_valid = 1'b1;
      r.primary_duty = fold_duty(tick_total, primary_ms, slbc_pkg::PRIMARY_SCALE);
      r.secondary_duty = fold_duty(tick_total, secondary_ms, slbc_pkg::SECONDARY_SCALE);
      return r;
    end
    chosen = saved_rgb;
    temp = '0;
    case (it.status_code)
      slbc_pkg::STS_USB_MOUNTED: begin
        chosen = slbc_pkg::COLOR_GREEN;
        primary_ms = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BOOT_STARTED, slbc_pkg::STS_USB_UNMOUNTED: begin
        chosen = slbc_pkg::COLOR_RED;
        primary_ms = slbc_pkg::FAST_PERIOD;
      end
      slbc_pkg::STS_WRITE_START: begin
        temp = slbc_pkg::COLOR_RED;
        primary_ms = slbc_pkg::WRITE_PERIOD;
      end
      slbc_pkg::STS_WRITE_DONE: begin
        primary_ms = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BLE_CONN: begin
        chosen = slbc_pkg::COLOR_BLUE;
        if (secondary_fitted) secondary_ms = slbc_pkg::SLOW_PERIOD;
        else primary_ms = slbc_pkg::SLOW_PERIOD;
      end
      slbc_pkg::STS_BLE_DISC: begin
        chosen = slbc_pkg::COLOR_MAGENTA;
        if (secondary_fitted) secondary_ms = slbc_pkg::FAST_PERIOD;
        else primary_ms = slbc_pkg::FAST_PERIOD;
      end
      default: begin
      end
    endcase
    chosen = chosen & mask_rgb;
    if (temp != 0) begin
      r.color_valid = 1'b1;
      r.color = temp & mask_rgb;
      temp_shown = 1'b1;
    end else if (chosen != saved_rgb) begin
      r.color_valid = 1'b1;
      r.color = chosen;
      saved_rgb = chosen;
    end else if (temp_shown) begin
      r.color_valid = 1'b1;
      r.color = saved_rgb;
    end
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Sender: bursts of transfers separated by random gaps, some of them empty.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        owed_outputs.push_back(next_led_outputs(item));
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left--;
        end else if (queued_items.size() != 0) begin
          item <= queued_items.pop_front();
          item_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall style is redrawn at random among no stalls, random stalls and toggling runs.
  int stall_style = 0;
  int style_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(100, 600);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        case (stall_style)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            result_stall <= ~result_stall;
            hold_left = $urandom_range(0, 60);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    slbc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (owed_outputs.size() == 0) begin
        $error("result transfer with no item outstanding");
        failures++;
      end else begin
        want = owed_outputs.pop_front();
        compare_field("duty_valid", 32'(want.duty_valid), 32'(result.duty_valid));
        compare_field("primary_duty", 32'(want.primary_duty),
                      32'(result.primary_duty));
        compare_field("secondary_duty", 32'(want.secondary_duty),
                      32'(result.secondary_duty));
        compare_field("color_valid", 32'(want.color_valid), 32'(result.color_valid));
        compare_field("color", 32'(want.color), 32'(result.color));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        slbc_pkg::CFG_BRIGHTNESS_MASK: mask_rgb = cfg_data;
        slbc_pkg::CFG_LED_ACTIVE_HIGH: active_high_led = cfg_data[0];
        slbc_pkg::CFG_HAS_SECONDARY: secondary_fitted = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  task automatic queue_item(logic cmd, logic [2:0] code);
    slbc_pkg::item_t it;
    it.command = cmd;
    it.status_code = code;
    queued_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_items.size() != 0 || item_valid || owed_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(logic [slbc_pkg::ColorWidth-1:0] mask, logic high,
                                logic fitted);
    logic [1:0] regs[3];
    logic [slbc_pkg::ColorWidth-1:0] vals[3];
    regs[0] = slbc_pkg::CFG_BRIGHTNESS_MASK;
    regs[1] = slbc_pkg::CFG_LED_ACTIVE_HIGH;
    regs[2] = slbc_pkg::CFG_HAS_SECONDARY;
    vals[0] = mask;
    vals[1] = {{(slbc_pkg::ColorWidth-1){1'b0}}, high};
    vals[2] = {{(slbc_pkg::ColorWidth-1){1'b0}}, fitted};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk);
      while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [slbc_pkg::ColorWidth-1:0] masks[NumPhases];
    logic highs[NumPhases];
    logic fits[NumPhases];
    masks = '{slbc_pkg::COLOR_ALL, 24'h000000, slbc_pkg::COLOR_ALL, 24'h0, 24'h0,
              slbc_pkg::COLOR_ALL, 24'h0, slbc_pkg::COLOR_ALL};
    highs = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    fits = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    masks[3] = slbc_pkg::ColorWidth'($urandom_range(0, 24'hFFFFFF));
    masks[4] = slbc_pkg::ColorWidth'($urandom_range(0, 24'hFFFFFF));
    masks[6] = slbc_pkg::ColorWidth'($urandom_range(0, 24'hFFFFFF));
    highs[6] = 1'($urandom_range(0, 1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every status code once, repeats that must stay silent, then the
    // temporary colour followed by events that re-send the saved colour.
    queue_item(slbc_pkg::CMD_TICK, 3'd0);
    queue_item(slbc_pkg::CMD_TICK, 3'd7);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_USB_MOUNTED);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_USB_MOUNTED);
    queue_item(slbc_pkg::CMD_EVENT, STS_OTHER);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_BOOT_STARTED);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_USB_UNMOUNTED);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_BLE_CONN);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_BLE_DISC);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_WRITE_DONE);
    queue_item(slbc_pkg::CMD_TICK, 3'd5);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_WRITE_START);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_WRITE_DONE);
    queue_item(slbc_pkg::CMD_EVENT, STS_OTHER);
    queue_item(slbc_pkg::CMD_EVENT, slbc_pkg::STS_WRITE_START);
    queue_item(slbc_pkg::CMD_TICK, 3'd2);
    queue_item(slbc_pkg::CMD_TICK, 3'd4);

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        wait_drained();
        write_settings(masks[p], highs[p], fits[p]);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          queue_item(slbc_pkg::CMD_TICK, 3'($urandom_range(0, 7)));
        end else begin
          queue_item(slbc_pkg::CMD_EVENT, 3'($urandom_range(0, 7)));
        end
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (failures == 0 && owed_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
design/slbc_pkg.sv
design/slbc_lane.sv
design/status_led_breathing_controller_unit.sv
design/slbc_checker.sv
tb/sv/tb_status_led_breathing_controller_unit.sv
